>>> design/caa_pkg.sv
// shared widths, command codes and sequencer states of the centroid accumulator
package caa_pkg;

  localparam int DEF_CLUSTERS = 16;
  localparam int DEF_DIM_MAX  = 16;

  localparam int CMD_W     = 2;
  localparam int CL_IN_W   = 4;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = 48;
  localparam int COUNT_W   = 16;
  localparam int DIM_CFG_W = 5;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = DIM_CFG_W'(16);

  // one quotient bit per divider step
  localparam int DIV_STEPS = SUM_W;
  localparam int ITER_W    = $clog2(DIV_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_FIND  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_RD,
    S_ADD,
    S_LOAD,
    S_DIV,
    S_WB
  } state_t;

endpackage

>>> design/centroid_accumulate_average_unit.sv
// k-means centroid accumulator: per-cluster coordinate sums, point counts, serial averaging
//
// Usage: a request is taken on a clock edge with start high and busy low. in_cmd selects
// clear cluster, add coordinate or find center; in_cluster picks the centroid, and for
// add in_coord_index and in_coord_value give the coordinate. cfg_dimension sets the number
// of coordinates in use; cfg_ready is always high, write it only while busy is low.
// Find center sends one result per coordinate in use on out_index, out_center_value,
// out_last and out_was_empty, each present for exactly one cycle with out_valid high.
// The receiver has no way to hold results back, so none is ever stalled or dropped.
// Sequence, from the accepting edge until the next request can be taken:
//   add: accept, sum memory read, write back;
//   clear: accept, then the cluster's row zeroed one coordinate per cycle, count too;
//   find center with a nonzero count: accept, then per coordinate in use: read, load,
//   48 steps of the shared restoring divider, write back; the divider sets the pace;
//   find center on an empty cluster: accept, then per coordinate: read, load and emit;
//   ignored requests (bad cluster, index past the dimension, unused command): accept only.
// A result shows the cycle after its write back (or empty load); it overlaps the next read.
// Reset: rst_n low clears control state and dimension (16), then a clearing pass over
// every cluster zeroes sums and counts with busy high; config still works.
module centroid_accumulate_average_unit
  import caa_pkg::*;
#(
  parameter int CLUSTERS = DEF_CLUSTERS,
  parameter int DIM_MAX  = DEF_DIM_MAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [CMD_W-1:0]            in_cmd,
  input  logic [CL_IN_W-1:0]          in_cluster,
  input  logic [IDX_W-1:0]            in_coord_index,
  input  logic signed [VAL_W-1:0]     in_coord_value,
  // result channel
  output logic                        out_valid,
  output logic [IDX_W-1:0]            out_index,
  output logic signed [SUM_W-1:0]     out_center_value,
  output logic                        out_last,
  output logic                        out_was_empty,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [DIM_CFG_W-1:0]        cfg_dimension
);

  // address widths for the cluster and coordinate parts of the sum memory
  localparam int CW  = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int DW  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int DCW = $clog2(DIM_MAX + 1);
  localparam int CMP_W = (DCW > DIM_CFG_W) ? DCW : DIM_CFG_W;
  localparam int CLC_W = ($clog2(CLUSTERS + 1) > CL_IN_W) ? $clog2(CLUSTERS + 1) : CL_IN_W;
  localparam int SUM_DEPTH = CLUSTERS * (1 << DW);

  localparam logic [CW-1:0]     CL_LAST   = CW'(CLUSTERS - 1);
  localparam logic [DW-1:0]     DIM_LAST  = DW'(DIM_MAX - 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_STEPS - 1);

  // sums: row per cluster, coordinate in the low address bits
  logic [SUM_W-1:0]   sum_mem [0:SUM_DEPTH-1];
  logic [COUNT_W-1:0] cnt_mem [0:CLUSTERS-1];
  logic [SUM_W-1:0]   sum_rdata_r;
  logic [COUNT_W-1:0] cnt_rdata_r;

  state_t             state_r, state_nxt;
  logic               all_r, all_nxt;        // clearing pass over every cluster
  logic [CW-1:0]      cl_r, cl_nxt;
  logic [DW-1:0]      idx_r, idx_nxt;
  logic [DW-1:0]      last_r, last_nxt;      // last coordinate in use, latched per request
  cmd_t               cmd_r, cmd_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic               neg_r, neg_nxt;        // sign of the dividend
  logic [SUM_W-1:0]   quo_r, quo_nxt;        // dividend shifts out, quotient shifts in
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic [DIM_CFG_W-1:0] dim_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_index_r;
  logic [SUM_W-1:0]   out_value_r;
  logic               out_last_r;
  logic               out_empty_r;

  logic [DCW-1:0]     dim_use;
  logic               cl_ok, ci_ok;
  logic               sum_we, cnt_we;
  logic [SUM_W-1:0]   sum_wdata;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               emit, emit_empty;
  logic [SUM_W-1:0]   emit_value;
  logic [COUNT_W:0]   rem_sh;
  logic               rem_ge;
  logic [CW+DW-1:0]   sum_addr;

  // dimension zero acts as one, anything past DIM_MAX as DIM_MAX
  always_comb begin
    if (dim_r == '0) begin
      dim_use = DCW'(1);
    end else if (CMP_W'(dim_r) > CMP_W'(DIM_MAX)) begin
      dim_use = DCW'(DIM_MAX);
    end else begin
      dim_use = DCW'(dim_r);
    end
  end

  assign cl_ok    = CLC_W'(in_cluster) < CLC_W'(CLUSTERS);
  assign ci_ok    = CMP_W'(in_coord_index) < CMP_W'(dim_use);
  assign sum_addr = {cl_r, idx_r};

  // one restoring-divider step: bring down the next dividend bit, try the subtract
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, cnt_rdata_r};

  always_comb begin
    state_nxt  = state_r;
    all_nxt    = all_r;
    cl_nxt     = cl_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    neg_nxt    = neg_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    iter_nxt   = iter_r;
    sum_we     = 1'b0;
    sum_wdata  = '0;
    cnt_we     = 1'b0;
    cnt_wdata  = '0;
    emit       = 1'b0;
    emit_empty = 1'b0;
    emit_value = sum_rdata_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cl_nxt   = CW'(in_cluster);
          idx_nxt  = (cmd_t'(in_cmd) == CMD_ADD) ? DW'(in_coord_index) : '0;
          last_nxt = DW'(dim_use - DCW'(1));
          cmd_nxt  = cmd_t'(in_cmd);
          val_nxt  = in_coord_value;
          all_nxt  = 1'b0;
          if (cl_ok) begin
            case (cmd_t'(in_cmd))
              CMD_CLEAR: state_nxt = S_CLR;
              CMD_ADD: begin
                if (ci_ok) begin
                  state_nxt = S_RD;
                end
              end
              CMD_FIND:  state_nxt = S_RD;
              default:   state_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_CLR: begin
        sum_we = 1'b1;
        cnt_we = (idx_r == '0);
        if (idx_r == DIM_LAST) begin
          idx_nxt = '0;
          if (!all_r || cl_r == CL_LAST) begin
            all_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            cl_nxt = cl_r + CW'(1);
          end
        end else begin
          idx_nxt = idx_r + DW'(1);
        end
      end

      // sum and count reads land at the end of this cycle
      S_RD: begin
        state_nxt = (cmd_r == CMD_ADD) ? S_ADD : S_LOAD;
      end

      S_ADD: begin
        sum_we    = 1'b1;
        sum_wdata = sum_rdata_r + {{(SUM_W-VAL_W){val_r[VAL_W-1]}}, val_r};
        // count a point on its last coordinate, saturating
        if (idx_r == last_r && cnt_rdata_r != {COUNT_W{1'b1}}) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata_r + COUNT_W'(1);
        end
        state_nxt = S_IDLE;
      end

      S_LOAD: begin
        if (cnt_rdata_r == '0) begin
          // empty cluster: pass the stored sum through untouched
          emit       = 1'b1;
          emit_empty = 1'b1;
          if (idx_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + DW'(1);
            state_nxt = S_RD;
          end
        end else begin
          neg_nxt   = sum_rdata_r[SUM_W-1];
          quo_nxt   = sum_rdata_r[SUM_W-1] ? (SUM_W'(0) - sum_rdata_r) : sum_rdata_r;
          rem_nxt   = '0;
          iter_nxt  = '0;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt  = rem_ge ? COUNT_W'(rem_sh - {1'b0, cnt_rdata_r}) : COUNT_W'(rem_sh);
        quo_nxt  = {quo_r[SUM_W-2:0], rem_ge};
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_LAST) begin
          state_nxt = S_WB;
        end
      end

      S_WB: begin
        sum_we     = 1'b1;
        sum_wdata  = neg_r ? (SUM_W'(0) - quo_r) : quo_r;
        emit       = 1'b1;
        emit_value = sum_wdata;
        if (idx_r == last_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + DW'(1);
          state_nxt = S_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      all_r       <= 1'b1;
      cl_r        <= '0;
      idx_r       <= '0;
      dim_r       <= DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      all_r       <= all_nxt;
      cl_r        <= cl_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) begin
        dim_r <= cfg_dimension;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    cmd_r  <= cmd_nxt;
    val_r  <= val_nxt;
    neg_r  <= neg_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    iter_r <= iter_nxt;
    if (emit) begin
      out_index_r <= IDX_W'(idx_r);
      out_value_r <= emit_value;
      out_last_r  <= (idx_r == last_r);
      out_empty_r <= emit_empty;
    end
  end

  // sum memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    sum_rdata_r <= sum_mem[sum_addr];
  end

  // count memory, addressed by the current cluster
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cl_r] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[cl_r];
  end

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_index        = out_index_r;
  assign out_center_value = out_value_r;
  assign out_last         = out_last_r;
  assign out_was_empty    = out_empty_r;

endmodule

>>> design/caa_check.sv
// port-level checks on the centroid accumulator and their bind to the top level
module caa_check (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // reset leaves no result on the port
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // every result comes from work the block was busy with
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding busy cycle");

  // each coordinate needs at least a read before it can be emitted
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  // more results pending keeps the block busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("block idle in the middle of a find center run");

  // the last result ends the run
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("block still busy at the last result");

endmodule

bind centroid_accumulate_average_unit caa_check u_caa_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);

>>> verif/tb_centroid_accumulate_average_unit.sv
// testbench for the k-means centroid accumulator: request driver, result monitor, scoreboard
`timescale 1ns / 1ps

module tb_centroid_accumulate_average_unit
  import caa_pkg::*;
();

  // cmd 3 has no package name; the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [VAL_W-1:0]   VAL_MAX   = 16'h7FFF;
  localparam logic [VAL_W-1:0]   VAL_MIN   = 16'h8000;
  localparam logic [COUNT_W-1:0] COUNT_TOP = 16'hFFFF;

  // trailing non-result work is at most a clear of one cluster
  localparam int SETTLE_CYCLES = 40;
  // sized for the worst case, every request a full 16-coordinate find
  localparam longint LIMIT_NS  = 3_000_000;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CL_IN_W-1:0] cluster;
    logic [IDX_W-1:0]   coord_index;
    logic [VAL_W-1:0]   coord_value;
  } centroid_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [SUM_W-1:0] center;
    logic             last;
    logic             was_empty;
  } center_res_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [CMD_W-1:0]       in_cmd = CMD_CLEAR;
  logic [CL_IN_W-1:0]     in_cluster = '0;
  logic [IDX_W-1:0]       in_coord_index = '0;
  logic signed [VAL_W-1:0] in_coord_value = '0;
  logic                   out_valid;
  logic [IDX_W-1:0]       out_index;
  logic signed [SUM_W-1:0] out_center_value;
  logic                   out_last;
  logic                   out_was_empty;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DIM_CFG_W-1:0]   cfg_dimension = DIM_RESET;

  centroid_accumulate_average_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_cluster       (in_cluster),
    .in_coord_index   (in_coord_index),
    .in_coord_value   (in_coord_value),
    .out_valid        (out_valid),
    .out_index        (out_index),
    .out_center_value (out_center_value),
    .out_last         (out_last),
    .out_was_empty    (out_was_empty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_dimension    (cfg_dimension)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow copy of the block's sums, counts and dimension register
  logic [SUM_W-1:0]     sum_shadow [DEF_CLUSTERS][DEF_DIM_MAX];
  logic [COUNT_W-1:0]   count_shadow [DEF_CLUSTERS];
  logic [DIM_CFG_W-1:0] dim_shadow = DIM_RESET;

  centroid_req_t pending_q[$];   // requests waiting for the driver
  center_res_t   center_q[$];    // predicted center results, oldest first
  centroid_req_t cur_req;        // request currently presented
  int            gap_left = 0;
  bit            idle_en = 1'b1;

  int fail_count = 0;
  int req_count = 0;
  int result_count = 0;
  int find_count = 0;
  int empty_find_count = 0;
  int dim_writes = 0;

  initial begin
    for (int c = 0; c < DEF_CLUSTERS; c++) begin
      count_shadow[c] = '0;
      for (int i = 0; i < DEF_DIM_MAX; i++) sum_shadow[c][i] = '0;
    end
  end

  // zero reads as 1, anything past DIM_MAX as DIM_MAX
  function automatic int dim_in_effect(logic [DIM_CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > DEF_DIM_MAX) return DEF_DIM_MAX;
    return int'(d);
  endfunction

  // signed 48-bit sum over a nonzero count, rounded toward zero
  function automatic logic [SUM_W-1:0] average_toward_zero(logic [SUM_W-1:0] s,
                                                            logic [COUNT_W-1:0] n);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] quo;
    mag = s[SUM_W-1] ? (48'd0 - s) : s;
    quo = mag / {32'd0, n};
    return s[SUM_W-1] ? (48'd0 - quo) : quo;
  endfunction

  // update the shadow state for one accepted request and queue its results
  task automatic apply_centroid_req(input centroid_req_t r);
    int               d;
    logic [COUNT_W-1:0] n;
    center_res_t      e;
    d = dim_in_effect(dim_shadow);
    case (r.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < DEF_DIM_MAX; i++) sum_shadow[r.cluster][i] = '0;
        count_shadow[r.cluster] = '0;
      end
      CMD_ADD: begin
        // an index past the dimension in use changes nothing
        if (int'(r.coord_index) < d) begin
          sum_shadow[r.cluster][r.coord_index] = sum_shadow[r.cluster][r.coord_index] +
            {{(SUM_W-VAL_W){r.coord_value[VAL_W-1]}}, r.coord_value};
          if (int'(r.coord_index) == d - 1 && count_shadow[r.cluster] != COUNT_TOP)
            count_shadow[r.cluster] = count_shadow[r.cluster] + 1'b1;
        end
      end
      CMD_FIND: begin
        n = count_shadow[r.cluster];
        find_count++;
        if (n == 0) empty_find_count++;
        for (int i = 0; i < d; i++) begin
          // in-place division, count left as it is
          if (n != 0)
            sum_shadow[r.cluster][i] = average_toward_zero(sum_shadow[r.cluster][i], n);
          e.index     = IDX_W'(i);
          e.center    = sum_shadow[r.cluster][i];
          e.last      = (i == d - 1);
          e.was_empty = (n == 0);
          center_q.push_back(e);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t %s", $realtime, msg);
  endtask

  // request driver: one item held until start && !busy, random idle bursts if idle_en is set
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (start) begin
        // the presented request was taken at this edge
        apply_centroid_req(cur_req);
        req_count++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() != 0 && idle_en && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 19) - 1;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_req = pending_q.pop_front();
        start          <= 1'b1;
        in_cmd         <= cur_req.cmd;
        in_cluster     <= cur_req.cluster;
        in_coord_index <= cur_req.coord_index;
        in_coord_value <= cur_req.coord_value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor: every strobed result is checked against the oldest prediction
  always @(posedge clk) begin
    center_res_t e;
    if (rst_n && out_valid) begin
      result_count++;
      if (center_q.size() == 0) begin
        note_failure($sformatf("unexpected result: idx %0d value %0d last %0b empty %0b",
                               out_index, out_center_value, out_last, out_was_empty));
      end else begin
        e = center_q.pop_front();
        if (out_index !== e.index || out_center_value !== e.center ||
            out_last !== e.last || out_was_empty !== e.was_empty)
          note_failure($sformatf({"center result differs: expected idx %0d value %0d ",
                                  "last %0b empty %0b, got idx %0d value %0d last %0b ",
                                  "empty %0b"},
                                 e.index, $signed(e.center), e.last, e.was_empty,
                                 out_index, out_center_value, out_last, out_was_empty));
      end
    end
  end

  task automatic push_req(input logic [CMD_W-1:0] cmd, input int cl, input int ci,
                          input logic [VAL_W-1:0] v);
    centroid_req_t r;
    r.cmd         = cmd;
    r.cluster     = CL_IN_W'(cl);
    r.coord_index = IDX_W'(ci);
    r.coord_value = v;
    pending_q.push_back(r);
  endtask

  // coordinate values lean on the extremes now and then
  function automatic logic [VAL_W-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      default: return VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // wait until the driver is empty, all results are in, and the block is idle
  task automatic wait_quiet();
    do @(negedge clk); while (pending_q.size() != 0 || start || center_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_dimension(input logic [DIM_CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_dimension <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    dim_shadow = v;
    dim_writes++;
  endtask

  // random traffic: mostly whole points, with finds, clears, partial points and noise
  task automatic fill_random(input int budget);
    int d;
    int used;
    int cl;
    int ci;
    int sel;
    int len;
    d = dim_in_effect(dim_shadow);
    used = 0;
    while (used < budget) begin
      sel = $urandom_range(0, 99);
      // most traffic goes to a few clusters so finds see accumulated data
      cl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      if (sel < 55) begin
        // whole point, or now and then a point cut short
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, d) : d;
        for (int i = 0; i < len; i++) push_req(CMD_ADD, cl, i, pick_coord());
        used += len;
      end else if (sel < 72) begin
        push_req(CMD_FIND, cl, $urandom_range(0, 15), pick_coord());
        used++;
      end else if (sel < 80) begin
        push_req(CMD_CLEAR, cl, $urandom_range(0, 15), pick_coord());
        used++;
      end else if (sel < 92) begin
        // lone add at any index; past the dimension it is ignored
        ci = $urandom_range(0, 15);
        push_req(CMD_ADD, cl, ci, pick_coord());
        if (ci < d) used++;
      end else begin
        push_req(CMD_UNUSED, cl, $urandom_range(0, 15), pick_coord());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset dimension of 16
    push_req(CMD_FIND, 0, 0, '0);              // empty cluster straight after reset
    push_req(CMD_ADD, 15, 0, VAL_MAX);
    push_req(CMD_ADD, 15, 15, VAL_MIN);        // last index bumps the count
    push_req(CMD_FIND, 15, 15, '1);            // divide by one
    push_req(CMD_ADD, 15, 15, VAL_MIN);
    push_req(CMD_FIND, 15, 0, '0);             // odd sums truncate toward zero
    push_req(CMD_UNUSED, 15, 15, VAL_MAX);     // unused command does nothing
    push_req(CMD_ADD, 5, 3, 16'd5);            // sum without a finished point
    push_req(CMD_FIND, 5, 0, '0);              // empty count, stored sums come back
    push_req(CMD_CLEAR, 15, 0, '0);
    push_req(CMD_FIND, 15, 0, '0);
    wait_quiet();

    // dimension zero behaves as one
    write_dimension(5'd0);
    push_req(CMD_ADD, 7, 0, -16'sd7);
    push_req(CMD_ADD, 7, 1, 16'd123);          // index past the dimension, ignored
    push_req(CMD_ADD, 7, 0, '0);
    push_req(CMD_FIND, 7, 0, '0);
    wait_quiet();

    // oversized dimension behaves as DIM_MAX
    write_dimension(5'd31);
    push_req(CMD_FIND, 7, 0, '0);
    wait_quiet();

    write_dimension(5'd3);
    push_req(CMD_ADD, 9, 5, VAL_MAX);          // ignored
    push_req(CMD_ADD, 9, 0, '1);
    push_req(CMD_ADD, 9, 1, 16'd1);
    push_req(CMD_ADD, 9, 2, VAL_MIN);
    push_req(CMD_FIND, 9, 0, '0);
    wait_quiet();

    // random phases across several dimension settings
    write_dimension(5'd16);
    fill_random(20);
    wait_quiet();
    write_dimension(5'd4);
    fill_random(18);
    wait_quiet();
    write_dimension(5'd1);
    fill_random(18);
    wait_quiet();
    write_dimension(5'd2);
    fill_random(18);
    wait_quiet();
    write_dimension(DIM_CFG_W'($urandom_range(1, 16)));
    fill_random(18);
    wait_quiet();

    // last part: no idle bursts; repeated finds on a one-coordinate cluster first
    idle_en = 1'b0;
    write_dimension(5'd1);
    push_req(CMD_CLEAR, 12, 0, '0);
    for (int k = 0; k < 3; k++) push_req(CMD_ADD, 12, 0, pick_coord());
    push_req(CMD_FIND, 12, 0, '0);
    push_req(CMD_FIND, 12, 0, '0);
    wait_quiet();
    write_dimension(5'd16);
    fill_random(20);
    wait_quiet();

    $display("run covered %0d requests, %0d center results, %0d finds (%0d on empty clusters)",
             req_count, result_count, find_count, empty_find_count);
    $display("dimension register written %0d times incl. 0, 1, 31; repeated in-place finds",
             dim_writes);
    if (fail_count == 0 && center_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results still expected", center_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
design/caa_pkg.sv
design/centroid_accumulate_average_unit.sv
design/caa_check.sv
verif/tb_centroid_accumulate_average_unit.sv
